// ===== sv/class_priority_request_scheduler_macros.svh =====
// Assertion macros for the scheduler checker
`ifndef CLASS_PRIORITY_REQUEST_SCHEDULER_MACROS_SVH
`define CLASS_PRIORITY_REQUEST_SCHEDULER_MACROS_SVH

// Implication checked on every clock edge outside reset
`define CPRS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset
`define CPRS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/cprs_pkg.sv =====
// ----------------------------------------------------------------------------
// cprs_pkg
// Shared types and codes of the class priority request scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
package cprs_pkg;
    localparam logic [1:0] MODE_FIFO = 2'd0;
    localparam logic [1:0] MODE_IMAGE = 2'd1;
    localparam logic [1:0] MODE_TEXT = 2'd2;
    localparam logic [1:0] MODE_LIFO = 2'd3;

    localparam logic [1:0] ST_QUEUED = 2'd0;
    localparam logic [1:0] ST_DISPATCHED = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam logic [15:0] AGE_MAX = 16'hFFFF;

    // commands from controller to datapath
    typedef struct packed {
        logic start;      // latch the input item, decide the pick
        logic rd_pick;    // issue the read of the picked entry
        logic cap_pick;   // capture read data of the picked entry
        logic age_rd;     // read the default entry under the walk pointer
        logic age_wr;     // write back the aged entry
        logic finish;     // update counters, load result
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic is_dequeue;
        logic reject;     // full enqueue or empty dequeue
        logic walk_done;  // walk covered every waiting default entry
    } sts_t;
endpackage
`default_nettype wire

// ===== sv/class_priority_request_scheduler.sv =====
// Enqueue and empty/full dequeue: accept, decide, then finish with result valid.
// Dispatch: accept, decide, read, capture, then the age walk over default-queue
// entries left waiting, reading and rewriting one entry per step through the age
// memory port; then finish. Next item is accepted once the result has been taken.
// rst_n asynchronous, active low: pointers, counters, mode cleared; entry
// memories are not cleared.
// ----------------------------------------------------------------------------
// class_priority_request_scheduler
// Shared-capacity two-queue request scheduler with FIFO, priority and LIFO modes.
// ----------------------------------------------------------------------------
`default_nettype none
module class_priority_request_scheduler #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        mode,
    input  wire logic [1:0]  req_class,
    input  wire logic [15:0] req_handle,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [15:0]      out_handle,
    output logic [1:0]       out_class,
    output logic [31:0]      out_arrival_index,
    output logic [15:0]      out_age,
    output logic [31:0]      out_dispatch_index
);
    logic [1:0]     sched_mode_reg;
    cprs_pkg::cmd_t cmd;
    cprs_pkg::sts_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sched_mode_reg <= cprs_pkg::MODE_FIFO;
        end
        else if (cfg_we)
        begin
            sched_mode_reg <= cfg_wdata;
        end
    end

    cprs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd));

    cprs_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .sched_mode(sched_mode_reg), .in_mode(mode),
        .in_class(req_class), .in_handle(req_handle), .cmd(cmd), .sts(sts),
        .res_status(status), .res_handle(out_handle), .res_class(out_class),
        .res_arrival(out_arrival_index), .res_age(out_age),
        .res_dispatch(out_dispatch_index));
endmodule
`default_nettype wire

// ===== sv/cprs_ram.sv =====
// ----------------------------------------------------------------------------
// cprs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module cprs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== sv/cprs_datapath.sv =====
// ----------------------------------------------------------------------------
// cprs_datapath
// Queue pointers, counters, entry memories, ageing walk and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module cprs_datapath #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [1:0]        sched_mode,
    input  wire logic              in_mode,
    input  wire logic [1:0]        in_class,
    input  wire logic [15:0]       in_handle,
    input  wire cprs_pkg::cmd_t    cmd,
    output cprs_pkg::sts_t         sts,
    output logic [1:0]             res_status,
    output logic [15:0]            res_handle,
    output logic [1:0]             res_class,
    output logic [31:0]            res_arrival,
    output logic [15:0]            res_age,
    output logic [31:0]            res_dispatch
);
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int PW = AW + 1;
    localparam int SPAN = 2 * QUEUE_DEPTH;
    localparam logic [PW:0] SPAN_V = (PW+1)'(SPAN);

    function automatic logic [PW-1:0] pnext(input logic [PW-1:0] p);
        logic [PW:0] s;
        s = {1'b0, p} + 1'b1;
        if (s >= SPAN_V)
        begin
            s = s - SPAN_V;
        end
        return s[PW-1:0];
    endfunction

    function automatic logic [PW-1:0] pprev(input logic [PW-1:0] p);
        logic [PW:0] s;
        s = {1'b0, p} + SPAN_V - 1'b1;
        if (s >= SPAN_V)
        begin
            s = s - SPAN_V;
        end
        return s[PW-1:0];
    endfunction

    function automatic logic [PW-1:0] pcount(input logic [PW-1:0] f, input logic [PW-1:0] r);
        logic [PW:0] s;
        s = {1'b0, r} + SPAN_V - {1'b0, f};
        if (s >= SPAN_V)
        begin
            s = s - SPAN_V;
        end
        return s[PW-1:0];
    endfunction

    function automatic logic [AW-1:0] slot(input logic [PW-1:0] p);
        logic [PW-1:0] s;
        s = p;
        if (s >= PW'(QUEUE_DEPTH))
        begin
            s = s - PW'(QUEUE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    logic [PW-1:0] hf_reg, hr_reg, lf_reg, lr_reg;
    logic [PW-1:0] fill_reg;
    logic [31:0]   arr_reg, disp_reg;

    logic          op_reg;
    logic          from_high_reg, reject_reg;
    logic [AW-1:0] pick_slot_reg;
    logic [15:0]   p_hdl_reg;
    logic [33:0]   p_meta_reg;
    logic [15:0]   p_age_reg;
    logic [PW-1:0] walk_ptr_reg, walk_cnt_reg, walk_n_reg;
    logic [AW-1:0] age_slot_reg;

    logic [PW-1:0] nh, nl;
    assign nh = pcount(hf_reg, hr_reg);
    assign nl = pcount(lf_reg, lr_reg);

    logic to_high;
    assign to_high = (sched_mode == cprs_pkg::MODE_IMAGE && in_class == 2'd1)
        || (sched_mode == cprs_pkg::MODE_TEXT && in_class == 2'd0);
    logic full_now;
    assign full_now = (fill_reg >= PW'(QUEUE_DEPTH))
        || (({1'b0, nh} + {1'b0, nl}) >= (PW+1)'(QUEUE_DEPTH));
    logic fh_now;
    assign fh_now = (sched_mode == cprs_pkg::MODE_IMAGE || sched_mode == cprs_pkg::MODE_TEXT)
        ? (nh != '0) : (nl == '0);

    // memory ports
    logic          hwe, lwe, awe;
    logic [AW-1:0] hwa, lwa, awa, hra, lra, ara;
    logic [15:0]   awd;
    logic [15:0]   hh_q, lh_q, la_q;
    logic [33:0]   hm_q, lm_q;

    assign hwe = cmd.start && !in_mode && !full_now && to_high;
    assign lwe = cmd.start && !in_mode && !full_now && !to_high;
    assign hwa = slot(hr_reg);
    assign lwa = slot(lr_reg);
    assign hra = pick_slot_reg;
    assign lra = cmd.rd_pick ? pick_slot_reg : slot(walk_ptr_reg);
    assign ara = cmd.rd_pick ? pick_slot_reg : slot(walk_ptr_reg);

    // age write port: zero on enqueue, else ageing write-back; the picked arrival stays in p_meta_reg
    logic [31:0] dlt;
    assign dlt = p_meta_reg[33:2] - lm_q[33:2];
    assign awe = lwe || cmd.age_wr;
    assign awa = lwe ? lwa : age_slot_reg;
    assign awd = lwe ? 16'd0
        : ((dlt != 32'd0 && !dlt[31] && la_q != cprs_pkg::AGE_MAX) ? la_q + 16'd1 : la_q);

    cprs_ram #(.WIDTH(16), .DEPTH(QUEUE_DEPTH)) u_hh (
        .clk(clk), .we(hwe), .waddr(hwa), .wdata(in_handle), .raddr(hra), .rdata(hh_q));
    cprs_ram #(.WIDTH(34), .DEPTH(QUEUE_DEPTH)) u_hm (
        .clk(clk), .we(hwe), .waddr(hwa), .wdata({arr_reg, in_class}), .raddr(hra),
        .rdata(hm_q));
    cprs_ram #(.WIDTH(16), .DEPTH(QUEUE_DEPTH)) u_lh (
        .clk(clk), .we(lwe), .waddr(lwa), .wdata(in_handle), .raddr(lra), .rdata(lh_q));
    cprs_ram #(.WIDTH(34), .DEPTH(QUEUE_DEPTH)) u_lm (
        .clk(clk), .we(lwe), .waddr(lwa), .wdata({arr_reg, in_class}), .raddr(lra),
        .rdata(lm_q));
    cprs_ram #(.WIDTH(16), .DEPTH(QUEUE_DEPTH)) u_la (
        .clk(clk), .we(awe), .waddr(awa), .wdata(awd), .raddr(ara), .rdata(la_q));

    assign sts.is_dequeue = op_reg;
    assign sts.reject = reject_reg;
    assign sts.walk_done = (walk_cnt_reg == walk_n_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hf_reg <= '0;
            hr_reg <= '0;
            lf_reg <= '0;
            lr_reg <= '0;
            fill_reg <= '0;
            arr_reg <= '0;
            disp_reg <= '0;
            op_reg <= 1'b0;
            reject_reg <= 1'b0;
            walk_cnt_reg <= '0;
            walk_n_reg <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                op_reg <= in_mode;
                if (!in_mode)
                begin
                    reject_reg <= full_now;
                    if (!full_now)
                    begin
                        if (to_high)
                        begin
                            hr_reg <= pnext(hr_reg);
                        end
                        else
                        begin
                            lr_reg <= pnext(lr_reg);
                        end
                        fill_reg <= fill_reg + 1'b1;
                        arr_reg <= arr_reg + 32'd1;
                    end
                end
                else
                begin
                    reject_reg <= (nh == '0 && nl == '0);
                    if (nh != '0 || nl != '0)
                    begin
                        if (fh_now)
                        begin
                            hf_reg <= pnext(hf_reg);
                        end
                        else if (sched_mode == cprs_pkg::MODE_LIFO)
                        begin
                            lr_reg <= pprev(lr_reg);
                        end
                        else
                        begin
                            lf_reg <= pnext(lf_reg);
                        end
                    end
                end
            end
            if (cmd.cap_pick)
            begin
                // walk the default queue as it stands after the pick
                walk_cnt_reg <= '0;
                walk_n_reg <= nl;
            end
            if (cmd.age_wr)
            begin
                walk_cnt_reg <= walk_cnt_reg + 1'b1;
            end
            if (cmd.finish && op_reg && !reject_reg)
            begin
                if (fill_reg != '0)
                begin
                    fill_reg <= fill_reg - 1'b1;
                end
                disp_reg <= disp_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            from_high_reg <= fh_now;
            pick_slot_reg <= fh_now ? slot(hf_reg)
                : ((sched_mode == cprs_pkg::MODE_LIFO) ? slot(pprev(lr_reg)) : slot(lf_reg));
        end
        if (cmd.cap_pick)
        begin
            p_hdl_reg <= from_high_reg ? hh_q : lh_q;
            p_meta_reg <= from_high_reg ? hm_q : lm_q;
            p_age_reg <= from_high_reg ? 16'd0 : la_q;
            walk_ptr_reg <= lf_reg;
        end
        if (cmd.age_rd)
        begin
            age_slot_reg <= slot(walk_ptr_reg);
        end
        // hold the read address until the write-back, then advance
        if (cmd.age_wr)
        begin
            walk_ptr_reg <= pnext(walk_ptr_reg);
        end
        if (cmd.finish)
        begin
            if (!op_reg)
            begin
                res_status <= reject_reg ? cprs_pkg::ST_FULL : cprs_pkg::ST_QUEUED;
            end
            else
            begin
                res_status <= reject_reg ? cprs_pkg::ST_EMPTY : cprs_pkg::ST_DISPATCHED;
            end
            if (op_reg && !reject_reg)
            begin
                res_handle <= p_hdl_reg;
                res_class <= p_meta_reg[1:0];
                res_arrival <= p_meta_reg[33:2];
                res_age <= p_age_reg;
                res_dispatch <= disp_reg;
            end
            else
            begin
                res_handle <= '0;
                res_class <= '0;
                res_arrival <= '0;
                res_age <= '0;
                res_dispatch <= '0;
            end
        end
    end
endmodule
`default_nettype wire

// ===== sv/cprs_ctrl.sv =====
// ----------------------------------------------------------------------------
// cprs_ctrl
// Sequencer: pick, ageing walk over the default queue, result handshake.
// ----------------------------------------------------------------------------
`default_nettype none
module cprs_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire cprs_pkg::sts_t sts,
    output cprs_pkg::cmd_t      cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_CAP = 3'd3;
    localparam logic [2:0] S_ARD = 3'd4;
    localparam logic [2:0] S_AWAIT = 3'd5;
    localparam logic [2:0] S_AWR = 3'd6;
    localparam logic [2:0] S_FIN = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       ov_reg, ov_next;

    assign in_ready = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid = ov_reg;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        ov_next = ov_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.start = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = (sts.is_dequeue && !sts.reject) ? S_READ : S_FIN;
            end
            S_READ:
            begin
                cmd.rd_pick = 1'b1;
                state_next = S_CAP;
            end
            S_CAP:
            begin
                cmd.cap_pick = 1'b1;
                state_next = S_ARD;
            end
            S_ARD:
            begin
                if (sts.walk_done)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.age_rd = 1'b1;
                    state_next = S_AWAIT;
                end
            end
            S_AWAIT:
            begin
                state_next = S_AWR;
            end
            S_AWR:
            begin
                cmd.age_wr = 1'b1;
                state_next = S_ARD;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                ov_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end
endmodule
`default_nettype wire

// ===== sv/cprs_checker.sv =====
// ----------------------------------------------------------------------------
// cprs_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "class_priority_request_scheduler_macros.svh"
module cprs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  status,
    input wire logic [31:0] out_arrival_index
);
    // no new transaction while a result waits
    `CPRS_ASSERT_IMP(a_no_overlap, clk, rst_n, out_valid, !in_ready)
    // a stalled result holds
    `CPRS_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status))
    // accepted transaction never yields a result in the next cycle
    `CPRS_ASSERT_NXT(a_latency, clk, rst_n, in_valid && in_ready, !out_valid)
    // non-dispatch results carry zero payload
    `CPRS_ASSERT_IMP(a_zero, clk, rst_n, out_valid && status != cprs_pkg::ST_DISPATCHED,
        out_arrival_index == 32'd0)
endmodule
bind class_priority_request_scheduler cprs_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .out_arrival_index(out_arrival_index));
`default_nettype wire
